>>> rtl/uint32_radix_to_ascii_assert.svh
// Assertion macros shared by the radix-to-ASCII converter RTL.
`ifndef UINT32_RADIX_TO_ASCII_ASSERT_SVH
`define UINT32_RADIX_TO_ASCII_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RTA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rta assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RTA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rta assertion failed");

`endif

>>> rtl/rta_pkg.sv
// Shared widths, constants and the digit-to-character mapping of the converter.
package rta_pkg;

   localparam int VALUE_W        = 32;
   localparam int RADIX_W        = 6;
   localparam int DIGIT_W        = 6;
   localparam int CHAR_W         = 7;
   localparam int REQ_DATA_W     = 40;
   localparam int RSP_DATA_W     = 8;
   localparam int MAX_DIGITS_DEF = 32;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

   localparam logic [DIGIT_W-1:0] DIGIT_TOP   = DIGIT_W'(35);
   localparam logic [DIGIT_W-1:0] DIGIT_ALPHA = DIGIT_W'(10);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
   // 'a' minus ten
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = CHAR_W'(87);

   // Map one digit to '0'..'9' or 'a'..'z'; out-of-range digits clamp to 'z'.
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] dc;
      dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
      if (dc < DIGIT_ALPHA) begin
         return CHAR_ZERO + CHAR_W'(dc);
      end else begin
         return CHAR_ALPHA + CHAR_W'(dc);
      end
   endfunction

endpackage

>>> rtl/rta_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
`include "uint32_radix_to_ascii_assert.svh"

module rta_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rta_pkg::VALUE_W-1:0]   dividend,
   input  logic [rta_pkg::RADIX_W-1:0]   divisor,
   output logic                          done,
   output logic [rta_pkg::VALUE_W-1:0]   quotient,
   output logic [rta_pkg::DIGIT_W-1:0]   remainder
);
   import rta_pkg::*;

   localparam int STEP_W = $clog2(VALUE_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0]  quo_ff, quo_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [RADIX_W-1:0]  div_ff, div_in;

   logic [DIGIT_W:0]    trial;
   logic                fits;

   // Shift the next dividend bit into the partial remainder and try a subtract
   assign trial = {rem_ff, quo_ff[VALUE_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      priority if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_W-2:0], fits};
         rem_in  = fits ? DIGIT_W'(trial - {1'b0, div_ff}) : DIGIT_W'(trial);
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath holds no reset
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `RTA_ASSERT_IMPL(a_rem_below_divisor, busy_ff, rem_ff < div_ff)
   `RTA_ASSERT_IMPL(a_done_not_busy, done_ff, !busy_ff)
   `RTA_ASSERT_NEXT(a_busy_ends_in_done, busy_ff && !start, busy_ff || done_ff)

endmodule

>>> rtl/uint32_radix_to_ascii.sv
// Top level: converts an unsigned 32-bit value into ASCII digits in radix 2 to 36.
//
// Each item takes a 32-bit value and a radix (0 and 1 act as 2, 37..63 act as 36)
// and yields its digits as ASCII characters '0'-'9','a'-'z', most significant
// first, with tlast on the final character; zero yields a single '0'. One item
// is worked on at a time: req_tready is high only while the block is idle. The
// bit-serial divider produces the digits one at a time, least significant first,
// and stores each remainder in the digit memory; each character then passes
// through the digit memory read and the output register, and a low rsp_tready
// holds the current character until it is taken.
`include "uint32_radix_to_ascii_assert.svh"

module uint32_radix_to_ascii #(
   parameter int MAX_DIGITS = rta_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rta_pkg::REQ_DATA_W-1:0]   req_tdata,   // value[31:0], radix[37:32]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rta_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // ascii_char[6:0]
   output logic                             rsp_tlast
);
   import rta_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_RD   = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [DIGIT_W-1:0]  rd_data_ff;
   logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];

   logic                req_fire;
   logic [VALUE_W-1:0]  req_value;
   logic [RADIX_W-1:0]  req_radix;
   logic [RADIX_W-1:0]  radix_sat;
   logic [RADIX_W-1:0]  radix_ff;

   logic                div_start;
   logic [VALUE_W-1:0]  div_dividend;
   logic                div_done;
   logic [VALUE_W-1:0]  div_quotient;
   logic [DIGIT_W-1:0]  div_remainder;
   logic                more_digits;

   // Unpack the request and clamp the radix
   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_radix = req_tdata[VALUE_W+RADIX_W-1:VALUE_W];
   assign radix_sat = (req_radix < RADIX_MIN) ? RADIX_MIN :
                      (req_radix > RADIX_MAX) ? RADIX_MAX : req_radix;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Keep dividing while the quotient is nonzero and the store has room
   assign more_digits  = (div_quotient != '0) && ((count_ff + CNT_W'(1)) != CNT_FULL);
   assign div_start    = req_fire || ((state_ff == ST_DIV) && div_done && more_digits);
   assign div_dividend = req_fire ? req_value : div_quotient;

   rta_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (req_fire ? radix_sat : radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Store one digit, then divide again or start emitting
            if (div_done) begin
               count_in = count_ff + CNT_W'(1);
               if (!more_digits) begin
                  rd_idx_in = count_ff[IDX_W-1:0];
                  state_in  = ST_RD;
               end
            end
         end
         ST_RD: begin
            // Memory read lands in rd_data_ff at this edge
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_ascii(rd_data_ff);
               rsp_last_in  = (rd_idx_ff == '0);
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - IDX_W'(1);
                  state_in  = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers hold no reset
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (req_fire) begin
         radix_ff <= radix_sat;
      end
   end

   // Digit store: remainders least significant first, read back in reverse
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV) && div_done) begin
         digit_mem[count_ff[IDX_W-1:0]] <= div_remainder;
      end
      rd_data_ff <= digit_mem[rd_idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CHAR_W){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   `RTA_ASSERT_IMPL(a_idle_no_rsp, req_tready, !rsp_tvalid)
   `RTA_ASSERT_NEXT(a_last_returns_idle, rsp_tvalid && rsp_tready && rsp_tlast, req_tready)
   `RTA_ASSERT_IMPL(a_last_at_top_digit, rsp_tvalid && rsp_tlast, rd_idx_ff == '0)
   `RTA_ASSERT_IMPL(a_count_in_range, state_ff == ST_RD, (count_ff != '0) && (count_ff <= CNT_FULL))

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the uint32 radix-to-ASCII converter: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module testbench;

   import rta_pkg::*;

   // One expected output character.
   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
   } ascii_char_type;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_LOWER = 7'h61;
   localparam int                HOLD_OFF_CYCLES = 1500;
   // Longest item is 32 binary digits.
   localparam int                DRAIN_CYCLES    = 1200;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;   // value[31:0], radix[37:32]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;         // ascii_char[6:0]
   logic                    rsp_tlast;

   ascii_char_type expected_chars[$];
   int          mismatch_count   = 0;
   bit          steady_flow      = 1'b0;
   bit          hold_off_pending = 1'b0;

   uint32_radix_to_ascii u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Saturate the radix into 2..36.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] radix);
      if (radix < RADIX_MIN) begin
         return RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return radix;
   endfunction

   // Divide down to digits, then queue the characters most significant first.
   function automatic void predict_ascii_digits(input logic [VALUE_W-1:0] value,
                                                input logic [RADIX_W-1:0] radix);
      logic [VALUE_W-1:0] rest;
      logic [VALUE_W-1:0] base;
      logic [DIGIT_W-1:0] digits [32];
      logic [DIGIT_W-1:0] d;
      ascii_char_type     c;
      int                 n;
      base = VALUE_W'(clamp_radix(radix));
      rest = value;
      n    = 0;
      do begin
         digits[n] = DIGIT_W'(rest % base);
         rest      = rest / base;
         n++;
      end while (rest != 0 && n < 32);
      for (int k = 0; k < n; k++) begin
         d = digits[n-1-k];
         c.ascii_char = (d < 10) ? ASCII_ZERO + CHAR_W'(d) : ASCII_LOWER + CHAR_W'(d - 10);
         c.last       = (k == n - 1);
         expected_chars.push_back(c);
      end
   endfunction

   // Sender gap: mostly none, some short, a few long.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_flow || pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Receiver stall length, never zero.
   function automatic int stall_len();
      if ($urandom_range(0, 99) < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Random radix: mostly legal, some outside 2..36 to exercise saturation.
   function automatic logic [RADIX_W-1:0] pick_radix();
      if ($urandom_range(0, 99) < 85) begin
         return RADIX_W'($urandom_range(2, 36));
      end
      return RADIX_W'($urandom_range(0, 63));
   endfunction

   // Random value shaped to hit digit-count boundaries and small widths.
   function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] radix);
      logic [63:0] power;
      logic [63:0] base;
      int          kind;
      int          steps;
      kind = $urandom_range(0, 9);
      unique case (kind)
         0, 1, 2, 3: begin
            return $urandom;
         end
         4, 5, 6: begin
            return $urandom & (32'hFFFF_FFFF >> $urandom_range(0, 31));
         end
         7: begin
            base  = 64'(clamp_radix(radix));
            power = 64'd1;
            steps = $urandom_range(1, 31);
            for (int i = 0; i < steps; i++) begin
               if (power * base <= 64'hFFFF_FFFF) begin
                  power = power * base;
               end
            end
            // step to just below, at, or above the power
            return VALUE_W'(power + 64'($urandom_range(0, 2)) - 64'd1);
         end
         8: begin
            return $urandom_range(0, 40);
         end
         default: begin
            return 32'hFFFF_FFFF - $urandom_range(0, 15);
         end
      endcase
   endfunction

   // Offer one item, hold it until accepted, then queue its characters.
   task automatic send_conversion(input logic [VALUE_W-1:0] value,
                                  input logic [RADIX_W-1:0] radix);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {2'b00, radix, value};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_ascii_digits(value, radix);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      logic [RADIX_W-1:0] radix;
      for (int i = 0; i < count; i++) begin
         radix = pick_radix();
         send_conversion(pick_value(radix), radix);
      end
   endtask

   // Extremes, zero, single digits, letter digits and radix saturation.
   task automatic test_directed();
      send_conversion(32'd0, 6'd10);
      send_conversion(32'd0, 6'd2);
      send_conversion(32'd0, 6'd36);
      send_conversion(32'd1, 6'd2);
      send_conversion(32'hFFFF_FFFF, 6'd2);
      send_conversion(32'hFFFF_FFFF, 6'd36);
      send_conversion(32'hFFFF_FFFF, 6'd16);
      send_conversion(32'hFFFF_FFFF, 6'd10);
      send_conversion(32'h8000_0000, 6'd2);
      send_conversion(32'd35, 6'd36);
      send_conversion(32'd36, 6'd36);
      send_conversion(32'd9, 6'd10);
      send_conversion(32'd10, 6'd10);
      send_conversion(32'd255, 6'd0);
      send_conversion(32'd255, 6'd1);
      send_conversion(32'd35, 6'd37);
      send_conversion(32'd1295, 6'd63);
      send_conversion(32'd12345, 6'd8);
      send_conversion(32'hDEAD_BEEF, 6'd16);
      send_conversion(32'd5, 6'd3);
      send_conversion(32'h7FFF_FFFF, 6'd7);
   endtask

   // No idling on either side.
   task automatic test_back_to_back();
      steady_flow = 1'b1;
      send_random(40);
      steady_flow = 1'b0;
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering items.
   task automatic test_backpressure();
      hold_off_pending = 1'b1;
      send_random(12);
   endtask

   task automatic test_random();
      send_random(397);
   endtask

   // Receiver: random ready bursts and stalls, plus one long hold-off on request.
   initial begin : receiver
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
         end else if (steady_flow || $urandom_range(0, 1) == 1) begin
            rsp_tready = 1'b1;
            n = steady_flow ? 1 : $urandom_range(1, 24);
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready = 1'b0;
            n = stall_len();
            repeat (n) @(negedge clock);
         end
      end
   end

   // Compare each accepted character with the oldest expectation.
   always @(posedge clock) begin : check_chars
      ascii_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected item: ascii_char %h last %b",
                     $time, rsp_tdata[CHAR_W-1:0], rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata[CHAR_W-1:0] !== want.ascii_char) begin
               $display("%0t: ascii_char expected %h actual %h",
                        $time, want.ascii_char, rsp_tdata[CHAR_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus, drain and verdict.
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_back_to_back();
      test_backpressure();
      test_random();
      req_tvalid = 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, expected_chars.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #100_000_000;
      $display("%0t: timeout with %0d items outstanding", $time, expected_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
